// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: lhs implies rhs");
// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: lhs implies rhs one cycle later");
`else
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif
`endif

// ===== rtl/bsfd_pkg.sv =====
// Shared types and constants of the byte-stuffed frame deframer.
// No dependencies; imported by the CRC unit, the deframer core and the bench.
package bsfd_pkg;

   localparam int PAYLOAD_LIMIT_DEF = 32;
   localparam int STORE_BYTES_DEF   = 37;

   localparam logic [7:0]  FLAG_RESET  = 8'h7E;
   localparam logic [7:0]  ESC_RESET   = 8'h7D;
   localparam logic [7:0]  ESC_XOR     = 8'h20;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam int          MIN_FRAME   = 5;
   localparam int          HDR_BYTES   = 3;
   localparam int          CRC_BYTES   = 2;

   localparam logic CSR_FLAG   = 1'b0;
   localparam logic CSR_ESCAPE = 1'b1;

   typedef enum logic [2:0] {
      KIND_HEADER   = 3'd0,
      KIND_PAYLOAD  = 3'd1,
      KIND_BADLEN   = 3'd2,
      KIND_BADCRC   = 3'd3,
      KIND_OVERFLOW = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CRC,
      ST_CHECK,
      ST_HDR,
      ST_PAY_RD,
      ST_PAY_WR,
      ST_STAT
   } state_type;

   typedef struct packed {
      logic init;
      logic step;
   } crc_ctl_type;

endpackage

// ===== rtl/bsfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 37
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bsfd_crc_unit.sv =====
// CRC-16 accumulator (poly 0x1021, MSB first) that folds in one byte per step.
// Depends on bsfd_pkg for the polynomial, the initial value and the control struct.
module bsfd_crc_unit (
   input  logic                 clock,
   input  bsfd_pkg::crc_ctl_type ctl,
   input  logic [7:0]           data,
   output logic [15:0]          crc
);
   import bsfd_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] next_crc;

   always_comb begin
      logic [15:0] c;
      c = crc_ff ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      next_crc = c;
   end

   always_comb begin
      crc_in = crc_ff;
      if (ctl.init) begin
         crc_in = CRC_INIT;
      end else if (ctl.step) begin
         crc_in = next_crc;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule

// ===== rtl/byte_stuffed_frame_deframer_core.sv =====
// Byte-stuffed frame deframer: unstuffs line bytes, stores a frame, checks it at close.
// An ordinary byte is taken while idle; a bad length or an overflow byte adds a status state.
// A closing flag on a frame of n bytes runs n-2 CRC reads through the frame RAM's read
// port, a CRC check and the header word, then a read and a write state per payload word,
// and a result word that waits on rsp_ready adds its wait; the block takes no input meanwhile.
// Reset clears frame state, flag 0x7E, escape 0x7D, not the RAM. Uses bsfd_pkg/ram/crc_unit.
module byte_stuffed_frame_deframer_core #(
   parameter int PAYLOAD_LIMIT = bsfd_pkg::PAYLOAD_LIMIT_DEF,
   parameter int STORE_BYTES   = bsfd_pkg::STORE_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_line_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [3:0] rsp_seq_num,
   output logic [3:0] rsp_ack_num,
   output logic [5:0] rsp_frame_type,
   output logic [1:0] rsp_frame_flags,
   output logic [5:0] rsp_payload_len,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);
   import bsfd_pkg::*;

   `include "assert_macros.svh"

   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam int CNT_W  = $clog2(STORE_BYTES + 1);

   state_type   state_ff, state_in;
   kind_type    status_kind_ff, status_kind_in;
   logic [7:0]  flag_ff, flag_in;
   logic [7:0]  esc_ff, esc_in;
   logic        in_frame_ff, in_frame_in;
   logic        esc_pend_ff, esc_pend_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] close_cnt_ff, close_cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic        rd_vld_ff, rd_vld_in;
   logic [7:0]  hdr0_ff, hdr0_in;
   logic [7:0]  hdr1_ff, hdr1_in;
   logic [7:0]  hdr2_ff, hdr2_in;
   logic [7:0]  prev1_ff, prev1_in;
   logic [7:0]  prev2_ff, prev2_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic [3:0]  rsp_seq_ff, rsp_seq_in;
   logic [3:0]  rsp_ack_ff, rsp_ack_in;
   logic [5:0]  rsp_type_ff, rsp_type_in;
   logic [1:0]  rsp_flags_ff, rsp_flags_in;
   logic [5:0]  rsp_len_ff, rsp_len_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]  ram_wr_data;
   logic        ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]  ram_rd_data;

   crc_ctl_type crc_ctl;
   logic [15:0] crc_val;

   logic        accept;
   logic        slot_free;
   logic        crc_issue;
   logic [CNT_W-1:0] crc_count;
   logic [7:0]  data_byte;
   logic        len_ok;
   logic        rsp_stalled;

   bsfd_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bsfd_crc_unit u_crc (
      .clock (clock),
      .ctl   (crc_ctl),
      .data  (ram_rd_data),
      .crc   (crc_val)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign crc_count = close_cnt_ff - CNT_W'(CRC_BYTES);
   assign crc_issue = (state_ff == ST_CRC) && (idx_ff < crc_count);
   assign data_byte = esc_pend_ff ? (req_line_byte ^ ESC_XOR) : req_line_byte;
   // The length word must be in range and agree with the number of stored words.
   assign len_ok    = (hdr2_ff <= 8'(PAYLOAD_LIMIT)) &&
                      (9'(fill_ff) == ({1'b0, hdr2_ff} + 9'(HDR_BYTES + CRC_BYTES)));
   assign rsp_stalled = rsp_valid_ff && !rsp_ready &&
                        (state_ff == ST_HDR || state_ff == ST_PAY_WR || state_ff == ST_STAT);

   always_comb begin
      state_in       = state_ff;
      status_kind_in = status_kind_ff;
      flag_in        = flag_ff;
      esc_in         = esc_ff;
      in_frame_in    = in_frame_ff;
      esc_pend_in    = esc_pend_ff;
      fill_in        = fill_ff;
      close_cnt_in   = close_cnt_ff;
      idx_in         = idx_ff;
      rd_vld_in      = 1'b0;
      hdr0_in        = hdr0_ff;
      hdr1_in        = hdr1_ff;
      hdr2_in        = hdr2_ff;
      prev1_in       = prev1_ff;
      prev2_in       = prev2_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_seq_in     = rsp_seq_ff;
      rsp_ack_in     = rsp_ack_ff;
      rsp_type_in    = rsp_type_ff;
      rsp_flags_in   = rsp_flags_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = fill_ff[ADDR_W-1:0];
      ram_wr_data    = data_byte;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = idx_ff[ADDR_W-1:0];
      crc_ctl.init   = 1'b0;
      crc_ctl.step   = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_FLAG:   flag_in = csr_wdata;
            CSR_ESCAPE: esc_in  = csr_wdata;
            default:    flag_in = flag_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_line_byte == flag_ff) begin
                  if (in_frame_ff && (fill_ff >= CNT_W'(MIN_FRAME))) begin
                     close_cnt_in = fill_ff;
                     idx_in       = '0;
                     crc_ctl.init = 1'b1;
                     if (len_ok) begin
                        state_in = ST_CRC;
                     end else begin
                        status_kind_in = KIND_BADLEN;
                        state_in       = ST_STAT;
                     end
                  end
                  in_frame_in = 1'b1;
                  fill_in     = '0;
                  esc_pend_in = 1'b0;
               end else if (in_frame_ff) begin
                  if (req_line_byte == esc_ff) begin
                     esc_pend_in = 1'b1;
                  end else begin
                     esc_pend_in = 1'b0;
                     if (fill_ff < CNT_W'(STORE_BYTES)) begin
                        ram_wr_en = 1'b1;
                        fill_in   = fill_ff + 1'b1;
                        prev1_in  = data_byte;
                        prev2_in  = prev1_ff;
                        if (fill_ff == CNT_W'(0)) begin
                           hdr0_in = data_byte;
                        end
                        if (fill_ff == CNT_W'(1)) begin
                           hdr1_in = data_byte;
                        end
                        if (fill_ff == CNT_W'(2)) begin
                           hdr2_in = data_byte;
                        end
                     end else begin
                        in_frame_in    = 1'b0;
                        fill_in        = '0;
                        status_kind_in = KIND_OVERFLOW;
                        state_in       = ST_STAT;
                     end
                  end
               end
            end
         end
         ST_CRC: begin
            // Reads run one word ahead of the CRC step because read data is registered.
            if (crc_issue) begin
               ram_rd_en = 1'b1;
               idx_in    = idx_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               crc_ctl.step = 1'b1;
            end
            if (!crc_issue && !rd_vld_ff) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (crc_val != {prev2_ff, prev1_ff}) begin
               status_kind_in = KIND_BADCRC;
               state_in       = ST_STAT;
            end else begin
               state_in = ST_HDR;
            end
         end
         ST_HDR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_HEADER;
               rsp_seq_in   = hdr0_ff[7:4];
               rsp_ack_in   = hdr0_ff[3:0];
               rsp_type_in  = hdr1_ff[7:2];
               rsp_flags_in = hdr1_ff[1:0];
               rsp_len_in   = hdr2_ff[5:0];
               rsp_data_in  = '0;
               rsp_last_in  = (hdr2_ff == 8'd0);
               idx_in       = CNT_W'(HDR_BYTES);
               state_in     = (hdr2_ff == 8'd0) ? ST_IDLE : ST_PAY_RD;
            end
         end
         ST_PAY_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_PAY_WR;
         end
         ST_PAY_WR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_PAYLOAD;
               rsp_seq_in   = '0;
               rsp_ack_in   = '0;
               rsp_type_in  = '0;
               rsp_flags_in = '0;
               rsp_len_in   = '0;
               rsp_data_in  = ram_rd_data;
               // The last payload word sits just ahead of the two CRC words.
               rsp_last_in  = (idx_ff == close_cnt_ff - CNT_W'(CRC_BYTES + 1));
               idx_in       = idx_ff + 1'b1;
               state_in     = rsp_last_in ? ST_IDLE : ST_PAY_RD;
            end
         end
         ST_STAT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = status_kind_ff;
               rsp_seq_in   = '0;
               rsp_ack_in   = '0;
               rsp_type_in  = '0;
               rsp_flags_in = '0;
               rsp_len_in   = '0;
               rsp_data_in  = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flag_ff      <= FLAG_RESET;
         esc_ff       <= ESC_RESET;
         in_frame_ff  <= 1'b0;
         esc_pend_ff  <= 1'b0;
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         esc_ff       <= esc_in;
         in_frame_ff  <= in_frame_in;
         esc_pend_ff  <= esc_pend_in;
         fill_ff      <= fill_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_kind_ff <= status_kind_in;
      close_cnt_ff   <= close_cnt_in;
      idx_ff         <= idx_in;
      hdr0_ff        <= hdr0_in;
      hdr1_ff        <= hdr1_in;
      hdr2_ff        <= hdr2_in;
      prev1_ff       <= prev1_in;
      prev2_ff       <= prev2_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_seq_ff     <= rsp_seq_in;
      rsp_ack_ff     <= rsp_ack_in;
      rsp_type_ff    <= rsp_type_in;
      rsp_flags_ff   <= rsp_flags_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_seq_num     = rsp_seq_ff;
   assign rsp_ack_num     = rsp_ack_ff;
   assign rsp_frame_type  = rsp_type_ff;
   assign rsp_frame_flags = rsp_flags_ff;
   assign rsp_payload_len = rsp_len_ff;
   assign rsp_data_byte   = rsp_data_ff;
   assign rsp_last        = rsp_last_ff;

   `ASSERT_IMPLIES(a_fill_in_range, clock, reset, 1'b1, fill_ff <= CNT_W'(STORE_BYTES))
   `ASSERT_IMPLIES(a_crc_frame_long, clock, reset, state_ff == ST_CRC, close_cnt_ff >= 6'd5)
   `ASSERT_NEXT(a_crc_read_returns, clock, reset, crc_issue, rd_vld_ff && state_ff == ST_CRC)
   `ASSERT_IMPLIES(a_no_load_when_full, clock, reset, rsp_stalled, state_in == state_ff)

endmodule

// ===== bench/byte_stuffed_frame_deframer_core_test.sv =====
// Self-checking bench for byte_stuffed_frame_deframer_core: a directed script and random
// framed traffic, each result word checked against a behavioral deframer in the bench.
// Depends on bsfd_pkg and the deframer RTL only.
module byte_stuffed_frame_deframer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bsfd_pkg::*;

   localparam int PAYLOAD_MAX   = PAYLOAD_LIMIT_DEF;
   localparam int STORE_MAX     = STORE_BYTES_DEF;
   localparam int SETTLE_CYCLES = 2 * STORE_BYTES_DEF + 16;
   localparam int ITEM_TARGET   = 460;
   localparam int PHASES        = 8;
   localparam int TIMEOUT_NS    = 5_000_000;
   localparam int SCRIPT_ROWS   = 33;

   typedef struct {
      kind_type   kind;
      logic [3:0] seq_num;
      logic [3:0] ack_num;
      logic [5:0] frame_type;
      logic [1:0] frame_flags;
      logic [5:0] payload_len;
      logic [7:0] data_byte;
      logic       last;
   } deframe_result_type;

   typedef enum {OP_RAW, OP_DATA, OP_CRC, OP_BADCRC, OP_SET_FLAG, OP_SET_ESCAPE} script_op_type;

   typedef struct {
      script_op_type op;
      logic [7:0]    value;
      int            count;
      bit            typed;
      kind_type      want;
   } script_row_type;

   typedef enum {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_line_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_kind;
   logic [3:0] rsp_seq_num;
   logic [3:0] rsp_ack_num;
   logic [5:0] rsp_frame_type;
   logic [1:0] rsp_frame_flags;
   logic [5:0] rsp_payload_len;
   logic [7:0] rsp_data_byte;
   logic       rsp_last;
   logic       csr_we = 1'b0;
   logic       csr_index = CSR_FLAG;
   logic [7:0] csr_wdata = 8'h00;

   byte_stuffed_frame_deframer_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_line_byte   (req_line_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_seq_num     (rsp_seq_num),
      .rsp_ack_num     (rsp_ack_num),
      .rsp_frame_type  (rsp_frame_type),
      .rsp_frame_flags (rsp_frame_flags),
      .rsp_payload_len (rsp_payload_len),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // Bench copy of the deframer state and its two registers.
   logic [7:0] cfg_flag = FLAG_RESET;
   logic [7:0] cfg_escape = ESC_RESET;
   bit         pd_in_frame = 1'b0;
   bit         pd_escaped = 1'b0;
   int         pd_fill = 0;
   logic [7:0] pd_store [STORE_MAX];

   deframe_result_type produced [$];
   deframe_result_type due_results [$];
   script_row_type     script [SCRIPT_ROWS];

   bit          failed = 1'b0;
   bit          mark_on = 1'b0;
   kind_type    mark_kind = KIND_HEADER;
   int          burst_left = 0;
   int          taken_words = 0;
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;

   function automatic deframe_result_type blank_result(kind_type k);
      deframe_result_type r;
      r.kind = k;
      r.seq_num = '0;
      r.ack_num = '0;
      r.frame_type = '0;
      r.frame_flags = '0;
      r.payload_len = '0;
      r.data_byte = '0;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic deframe_result_type status_result(kind_type k);
      deframe_result_type r;
      r = blank_result(k);
      r.last = 1'b1;
      return r;
   endfunction

   function automatic logic [15:0] crc16_over(int count);
      logic [15:0] acc;
      acc = CRC_INIT;
      for (int i = 0; i < count; i++) begin
         acc = acc ^ {pd_store[i], 8'h00};
         for (int j = 0; j < 8; j++) begin
            acc = acc[15] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
         end
      end
      return acc;
   endfunction

   // A byte can be carried when it is ordinary, or when its escaped form is.
   function automatic bit encodable(logic [7:0] b);
      logic [7:0] alt;
      alt = b ^ ESC_XOR;
      return (b != cfg_flag && b != cfg_escape) ||
             (cfg_flag != cfg_escape && alt != cfg_flag && alt != cfg_escape);
   endfunction

   function automatic logic [7:0] rand_body_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (!encodable(b)) b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   task automatic close_frame();
      int plen;
      deframe_result_type r;
      if (pd_fill >= MIN_FRAME) begin
         plen = int'(pd_store[2]);
         if (plen > PAYLOAD_MAX || pd_fill != plen + MIN_FRAME) begin
            produced.push_back(status_result(KIND_BADLEN));
         end else if (crc16_over(pd_fill - CRC_BYTES) !=
                      {pd_store[pd_fill - 2], pd_store[pd_fill - 1]}) begin
            produced.push_back(status_result(KIND_BADCRC));
         end else begin
            r = blank_result(KIND_HEADER);
            r.seq_num = pd_store[0][7:4];
            r.ack_num = pd_store[0][3:0];
            r.frame_type = pd_store[1][7:2];
            r.frame_flags = pd_store[1][1:0];
            r.payload_len = plen[5:0];
            r.last = (plen == 0);
            produced.push_back(r);
            for (int i = 0; i < plen; i++) begin
               r = blank_result(KIND_PAYLOAD);
               r.data_byte = pd_store[HDR_BYTES + i];
               r.last = (i + 1 == plen);
               produced.push_back(r);
            end
         end
      end
   endtask

   task automatic deframe_line_byte(input logic [7:0] raw);
      logic [7:0] b;
      b = raw;
      produced.delete();
      if (b == cfg_flag) begin
         if (pd_in_frame) close_frame();
         pd_in_frame = 1'b1;
         pd_fill = 0;
         pd_escaped = 1'b0;
      end else if (pd_in_frame) begin
         if (b == cfg_escape) begin
            pd_escaped = 1'b1;
         end else begin
            if (pd_escaped) begin
               b = b ^ ESC_XOR;
               pd_escaped = 1'b0;
            end
            if (pd_fill < STORE_MAX) begin
               pd_store[pd_fill] = b;
               pd_fill++;
            end else begin
               produced.push_back(status_result(KIND_OVERFLOW));
               pd_in_frame = 1'b0;
               pd_fill = 0;
            end
         end
      end
   endtask

   // Sends one line word in the current burst and predicts what it causes.
   task automatic send_line_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 6);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_line_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      deframe_line_byte(b);
      taken_words++;
      if (mark_on && produced.size() != 0) begin
         due_results.push_back(status_result(mark_kind));
      end else begin
         foreach (produced[i]) due_results.push_back(produced[i]);
      end
   endtask

   // Stuffs a frame byte; now and then escapes an ordinary byte or doubles the escape.
   task automatic send_data(input logic [7:0] b);
      logic [7:0] alt;
      alt = b ^ ESC_XOR;
      if ((b == cfg_flag || b == cfg_escape || $urandom_range(0, 15) == 0) &&
          cfg_flag != cfg_escape && alt != cfg_flag && alt != cfg_escape) begin
         if ($urandom_range(0, 7) == 0) send_line_byte(cfg_escape);
         send_line_byte(cfg_escape);
         send_line_byte(alt);
      end else begin
         send_line_byte(b);
      end
   endtask

   task automatic send_crc(input bit corrupt);
      logic [15:0] crc;
      crc = crc16_over(pd_fill);
      if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      send_data(crc[15:8]);
      send_data(crc[7:0]);
   endtask

   task automatic await_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] val);
      await_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FLAG) cfg_flag = val;
      else cfg_escape = val;
   endtask

   task automatic send_random_frame();
      int pick;
      int plen;
      int n;
      if (!pd_in_frame || $urandom_range(0, 15) == 0) send_line_byte(cfg_flag);
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
         // Well-formed frame; about one in six of them carries a damaged CRC.
         if ($urandom_range(0, 9) == 0) plen = PAYLOAD_MAX;
         else if ($urandom_range(0, 4) == 0) plen = $urandom_range(9, PAYLOAD_MAX - 1);
         else plen = $urandom_range(0, 8);
         send_data(rand_body_byte());
         send_data(rand_body_byte());
         send_data(plen[7:0]);
         repeat (plen) send_data(rand_body_byte());
         send_crc(pick >= 52);
      end else if (pick < 72) begin
         send_data(rand_body_byte());
         send_data(rand_body_byte());
         if ($urandom_range(0, 1) == 0) begin
            send_data(8'($urandom_range(PAYLOAD_MAX + 1, 255)));
            repeat ($urandom_range(0, 8)) send_data(rand_body_byte());
            send_crc(1'b0);
         end else begin
            plen = $urandom_range(0, 20);
            send_data(plen[7:0]);
            n = plen + ($urandom_range(0, 1) == 0 ? -1 : int'($urandom_range(1, 2)));
            repeat (n) send_data(rand_body_byte());
            send_crc(1'b0);
         end
      end else if (pick < 82) begin
         repeat ($urandom_range(STORE_MAX + 1, STORE_MAX + 7)) send_data(rand_body_byte());
      end else if (pick < 90) begin
         repeat ($urandom_range(0, MIN_FRAME - 1)) send_data(rand_body_byte());
      end else begin
         repeat ($urandom_range(1, 8)) begin
            n = $urandom_range(0, 7);
            if (n == 0) send_line_byte(cfg_flag);
            else if (n == 1) send_line_byte(cfg_escape);
            else send_line_byte(8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 7) == 0) send_line_byte(cfg_escape);
      send_line_byte(cfg_flag);
   endtask

   // The receiver switches between stall patterns, picked at random.
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(16, 96);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_OPEN: rsp_ready <= 1'b1;
         RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         RX_EVERY4: rsp_ready <= (rx_left % 4 == 0);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("field %s: expected %0h, actual %0h", name, want, got);
         failed = 1'b1;
      end
   endfunction

   always @(posedge clock) begin : watch_rsp
      deframe_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $error("result word with none expected, kind %0d", rsp_kind);
            failed = 1'b1;
         end else begin
            want = due_results.pop_front();
            check_field("kind", 8'(want.kind), 8'(rsp_kind));
            check_field("seq_num", 8'(want.seq_num), 8'(rsp_seq_num));
            check_field("ack_num", 8'(want.ack_num), 8'(rsp_ack_num));
            check_field("frame_type", 8'(want.frame_type), 8'(rsp_frame_type));
            check_field("frame_flags", 8'(want.frame_flags), 8'(rsp_frame_flags));
            check_field("payload_len", 8'(want.payload_len), 8'(rsp_payload_len));
            check_field("data_byte", want.data_byte, rsp_data_byte);
            check_field("last", 8'(want.last), 8'(rsp_last));
         end
      end
   end

   initial begin : stimulus
      int random_start;
      logic [7:0] flag_pick;
      logic [7:0] esc_pick;

      // Rows marked typed carry the status word they must produce.
      script = '{
         '{OP_RAW,        8'h55, 1, 1'b0, KIND_HEADER},
         '{OP_RAW,        8'h7E, 2, 1'b0, KIND_HEADER},
         '{OP_DATA,       8'h00, 4, 1'b0, KIND_HEADER},
         '{OP_RAW,        8'h7E, 1, 1'b0, KIND_HEADER},
         '{OP_DATA,       8'hFF, 2, 1'b0, KIND_HEADER},
         '{OP_DATA,       8'h00, 1, 1'b0, KIND_HEADER},
         '{OP_CRC,        8'h00, 1, 1'b0, KIND_HEADER},
         '{OP_RAW,        8'h7D, 1, 1'b0, KIND_HEADER},
         '{OP_RAW,        8'h7E, 1, 1'b0, KIND_HEADER},
         '{OP_RAW,        8'h7D, 2, 1'b0, KIND_HEADER},
         '{OP_RAW,        8'h5E, 1, 1'b0, KIND_HEADER},
         '{OP_DATA,       8'h03, 1, 1'b0, KIND_HEADER},
         '{OP_DATA,       8'h01, 1, 1'b0, KIND_HEADER},
         '{OP_DATA,       8'h7D, 1, 1'b0, KIND_HEADER},
         '{OP_CRC,        8'h00, 1, 1'b0, KIND_HEADER},
         '{OP_RAW,        8'h7E, 1, 1'b0, KIND_HEADER},
         '{OP_DATA,       8'h00, 3, 1'b0, KIND_HEADER},
         '{OP_BADCRC,     8'h00, 1, 1'b0, KIND_HEADER},
         '{OP_RAW,        8'h7E, 1, 1'b1, KIND_BADCRC},
         '{OP_DATA,       8'h00, 2, 1'b0, KIND_HEADER},
         '{OP_DATA,       8'h21, 1, 1'b0, KIND_HEADER},
         '{OP_DATA,       8'h00, 2, 1'b0, KIND_HEADER},
         '{OP_RAW,        8'h7E, 1, 1'b1, KIND_BADLEN},
         '{OP_DATA,       8'h00, 2, 1'b0, KIND_HEADER},
         '{OP_DATA,       8'h01, 1, 1'b0, KIND_HEADER},
         '{OP_CRC,        8'h00, 1, 1'b0, KIND_HEADER},
         '{OP_RAW,        8'h7E, 1, 1'b1, KIND_BADLEN},
         '{OP_SET_FLAG,   8'h55, 1, 1'b0, KIND_HEADER},
         '{OP_SET_ESCAPE, 8'h55, 1, 1'b0, KIND_HEADER},
         '{OP_RAW,        8'h55, 1, 1'b0, KIND_HEADER},
         '{OP_DATA,       8'h00, 3, 1'b0, KIND_HEADER},
         '{OP_CRC,        8'h00, 1, 1'b0, KIND_HEADER},
         '{OP_RAW,        8'h55, 1, 1'b0, KIND_HEADER}
      };
      foreach (pd_store[i]) pd_store[i] = 8'h00;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         mark_on = script[r].typed;
         mark_kind = script[r].want;
         case (script[r].op)
            OP_RAW: repeat (script[r].count) send_line_byte(script[r].value);
            OP_DATA: repeat (script[r].count) send_data(script[r].value);
            OP_CRC: send_crc(1'b0);
            OP_BADCRC: send_crc(1'b1);
            OP_SET_FLAG: write_csr(CSR_FLAG, script[r].value);
            default: write_csr(CSR_ESCAPE, script[r].value);
         endcase
      end
      mark_on = 1'b0;

      // Random traffic under a series of register settings, defaults and extremes first.
      random_start = taken_words;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin flag_pick = FLAG_RESET; esc_pick = ESC_RESET; end
            1: begin flag_pick = 8'h00; esc_pick = 8'hFF; end
            2: begin flag_pick = 8'hFF; esc_pick = 8'h00; end
            3: begin flag_pick = 8'hAA; esc_pick = 8'hAA; end
            4: begin flag_pick = 8'h40; esc_pick = 8'h60; end
            5, 6: begin
               flag_pick = 8'($urandom_range(0, 255));
               esc_pick = 8'($urandom_range(0, 255));
            end
            default: begin flag_pick = FLAG_RESET; esc_pick = ESC_RESET; end
         endcase
         write_csr(CSR_FLAG, flag_pick);
         write_csr(CSR_ESCAPE, esc_pick);
         while (taken_words < random_start +
                (phase + 1) * (ITEM_TARGET - random_start) / PHASES) send_random_frame();
      end

      await_idle();
      if (failed) begin
         $display("byte_stuffed_frame_deframer_core: mismatch");
      end else begin
         $display("byte_stuffed_frame_deframer_core: match");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("byte_stuffed_frame_deframer_core: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bsfd_pkg.sv
rtl/bsfd_ram.sv
rtl/bsfd_crc_unit.sv
rtl/byte_stuffed_frame_deframer_core.sv
bench/byte_stuffed_frame_deframer_core_test.sv
